@@ src/assert_macros.svh @@
// Assertion macros used by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same clock edge.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mptq_pkg.sv @@
// ----------------------------------------------------------------------------
// mptq_pkg
// Sizes, codes and types of the multilevel priority task queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mptq_pkg;

    localparam int LEVELS   = 4;
    localparam int DEPTH    = 16;

    localparam int ID_W     = 8;
    localparam int LVL_W    = 3;
    localparam int SLICE_W  = 11;
    localparam int UNIT_W   = 8;
    localparam int OCC_W    = 7;

    localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int LIDX_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ENTRIES  = LEVELS * DEPTH;
    localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TOT_W    = $clog2(ENTRIES + 1);

    localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(10);

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_BAD_LEVEL = 2'd3
    } status_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [SLICE_W-1:0] slice;
        logic [ID_W-1:0]    id;
    } entry_t;

endpackage

`default_nettype wire

@@ src/multilevel_priority_task_queue_unit.sv @@
// ----------------------------------------------------------------------------
// multilevel_priority_task_queue_unit
// Per-level FIFO rings in one entry memory; a pop takes the oldest task of
// the highest-priority non-empty level, a push appends to its level's ring.
// The result is registered and appears on the output register in the cycle after its input transaction.
// Throughput: one push or pop per cycle; input stalls only while a result
// waits on the output. Pointers, counts and a single memory port per
// direction are updated in the accept cycle.
// Reset: rings empty, pointers zero, slice_unit = 10; memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module multilevel_priority_task_queue_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration: slice_unit
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mptq_pkg::UNIT_W-1:0]     cfg_data,
    // input: tuser[0] opcode
    // tdata: [7:0] task_id, [10:8] level, [21:11] slice_in, [23:22] zero
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [mptq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                            s_axis_tuser,
    // output: tuser[1:0] status
    // tdata: [7:0] task_out, [18:8] slice_out, [21:19] level_out,
    //        [28:22] occupancy, [31:29] zero
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [mptq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [1:0]                           m_axis_tuser
);
    import mptq_pkg::*;

    // configuration register
    logic [UNIT_W-1:0] unit_reg;

    // ring state
    logic [PTR_W-1:0]  head_reg  [LEVELS];
    logic [PTR_W-1:0]  tail_reg  [LEVELS];
    logic [CNT_W-1:0]  count_reg [LEVELS];
    logic [PTR_W-1:0]  head_next [LEVELS];
    logic [PTR_W-1:0]  tail_next [LEVELS];
    logic [CNT_W-1:0]  count_next[LEVELS];
    logic [TOT_W-1:0]  total_reg;
    logic [TOT_W-1:0]  total_next;

    // entry memory
    entry_t            mem [ENTRIES];
    entry_t            rd_data_reg;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            wr_data;

    // output register
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic              out_pop_ok_reg;
    logic [SLICE_W-1:0] out_slice_reg;
    logic [LVL_W-1:0]  out_level_reg;
    logic [OCC_W-1:0]  out_occ_reg;

    status_t           out_status_next;
    logic              out_pop_ok_next;
    logic [SLICE_W-1:0] out_slice_next;
    logic [LVL_W-1:0]  out_level_next;
    logic [OCC_W-1:0]  out_occ_next;

    // input decode
    logic              in_accept;
    opcode_t           in_op;
    logic [ID_W-1:0]   in_id;
    logic [LVL_W-1:0]  in_level;
    logic [SLICE_W-1:0] in_slice;
    logic              level_bad;
    logic [LIDX_W-1:0] push_q;
    logic [SLICE_W-1:0] push_slice;
    logic              push_full;
    logic              pop_hit;
    logic [LIDX_W-1:0] pop_q;
    logic [TOT_W+OCC_W-1:0] occ_ext;

    // assertion helpers
    logic [TOT_W-1:0]  count_sum;
    logic              count_over;

    assign cfg_ready     = 1'b1;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    assign in_op    = opcode_t'(s_axis_tuser);
    assign in_id    = s_axis_tdata[7:0];
    assign in_level = s_axis_tdata[10:8];
    assign in_slice = s_axis_tdata[21:11];

    assign level_bad  = (in_level == LVL_W'(0)) || (in_level > LVL_W'(LEVELS));
    assign push_q     = LIDX_W'(in_level - LVL_W'(1));
    assign push_full  = (count_reg[push_q] >= CNT_W'(DEPTH));
    assign push_slice = (in_slice != '0) ? in_slice
                                         : SLICE_W'(SLICE_W'(in_level) * SLICE_W'(unit_reg));

    // highest priority non-empty level
    always_comb
    begin
        pop_hit = 1'b0;
        pop_q   = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                pop_hit = 1'b1;
                pop_q   = LIDX_W'(i);
            end
        end
    end

    assign wr_addr = ADDR_W'(ADDR_W'(push_q) * ADDR_W'(DEPTH)) + ADDR_W'(tail_reg[push_q]);
    assign rd_addr = ADDR_W'(ADDR_W'(pop_q) * ADDR_W'(DEPTH)) + ADDR_W'(head_reg[pop_q]);
    assign wr_data = '{slice: push_slice, id: in_id};
    assign wr_en   = in_accept && (in_op == OP_PUSH) && !level_bad && !push_full;
    assign rd_en   = in_accept && (in_op == OP_POP) && pop_hit;

    // ring bookkeeping
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
        end
        total_next = total_reg;
        if (wr_en)
        begin
            tail_next[push_q]  = (tail_reg[push_q] == PTR_W'(DEPTH - 1)) ? '0
                                 : tail_reg[push_q] + PTR_W'(1);
            count_next[push_q] = count_reg[push_q] + CNT_W'(1);
            total_next         = total_reg + TOT_W'(1);
        end
        else if (rd_en)
        begin
            head_next[pop_q]   = (head_reg[pop_q] == PTR_W'(DEPTH - 1)) ? '0
                                 : head_reg[pop_q] + PTR_W'(1);
            count_next[pop_q]  = count_reg[pop_q] - CNT_W'(1);
            total_next         = total_reg - TOT_W'(1);
        end
    end

    assign occ_ext      = (TOT_W + OCC_W)'(total_next);
    assign out_occ_next = occ_ext[OCC_W-1:0];

    // result fields other than the popped entry
    always_comb
    begin
        out_status_next = STAT_OK;
        out_pop_ok_next = 1'b0;
        out_slice_next  = '0;
        out_level_next  = '0;
        unique case (in_op)
            OP_PUSH:
            begin
                if (level_bad)
                begin
                    out_status_next = STAT_BAD_LEVEL;
                end
                else
                begin
                    out_status_next = push_full ? STAT_FULL : STAT_OK;
                    out_slice_next  = push_slice;
                    out_level_next  = in_level;
                end
            end
            OP_POP:
            begin
                if (pop_hit)
                begin
                    out_pop_ok_next = 1'b1;
                    out_level_next  = LVL_W'(pop_q) + LVL_W'(1);
                end
                else
                begin
                    out_status_next = STAT_EMPTY;
                end
            end
            default:
            begin
                out_status_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= UNIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= head_next[i];
                tail_reg[i]  <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
            total_reg <= total_next;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold result payload until the next input transaction
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_status_reg <= out_status_next;
            out_pop_ok_reg <= out_pop_ok_next;
            out_slice_reg  <= out_slice_next;
            out_level_reg  <= out_level_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000,
                            out_occ_reg,
                            out_level_reg,
                            out_pop_ok_reg ? rd_data_reg.slice : out_slice_reg,
                            out_pop_ok_reg ? rd_data_reg.id    : ID_W'(0)};

    always_comb
    begin
        count_sum  = '0;
        count_over = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            count_sum = count_sum + TOT_W'(count_reg[i]);
            if (count_reg[i] > CNT_W'(DEPTH))
            begin
                count_over = 1'b1;
            end
        end
    end

    `ASSERT_SAME(a_total_matches, 1'b1, total_reg == count_sum, "total count out of step")
    `ASSERT_SAME(a_no_overflow, 1'b1, !count_over, "level count above ring depth")
    `ASSERT_NEXT(a_pop_nonempty_ok,
                 in_accept && (in_op == OP_POP) && (total_reg != '0),
                 out_status_reg == STAT_OK && out_pop_ok_reg,
                 "pop on non-empty queue did not succeed")

endmodule

`default_nettype wire

@@ tb/mptq_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mptq_checker
// Watches the configuration, input and output channels of the task queue,
// keeps its own copy of the per-level rings and compares every output
// transaction field by field with the oldest predicted scheduling result.
// ----------------------------------------------------------------------------

module mptq_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [mptq_pkg::UNIT_W-1:0]        cfg_data,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    // tdata: [7:0] task_id, [10:8] level, [21:11] slice_in, [23:22] zero
    input  logic [mptq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: [0] opcode
    input  logic                               s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: [7:0] task_out, [18:8] slice_out, [21:19] level_out,
    //        [28:22] occupancy, [31:29] zero
    input  logic [mptq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: [1:0] status
    input  logic [1:0]                         m_axis_tuser,
    output int                                 fail_count,
    output int                                 awaiting
);

    import mptq_pkg::*;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    task_id;
        logic [SLICE_W-1:0] slice;
        logic [LVL_W-1:0]   level;
        logic [OCC_W-1:0]   occ;
    } sched_result_t;

    sched_result_t      sched_q[$];

    logic [ID_W-1:0]    ring_id    [LEVELS][DEPTH];
    logic [SLICE_W-1:0] ring_slice [LEVELS][DEPTH];
    int unsigned        ring_head  [LEVELS];
    int unsigned        ring_tail  [LEVELS];
    int unsigned        ring_count [LEVELS];
    logic [UNIT_W-1:0]  unit_now;

    // Apply one push or pop to the shadow rings and return what it reports.
    function automatic sched_result_t schedule_op(opcode_t op, logic [ID_W-1:0] tid,
                                                  logic [LVL_W-1:0] lvl,
                                                  logic [SLICE_W-1:0] sl_in);
        sched_result_t r;
        int            q;
        int            held;
        int            prod;
        bit            found;
        r        = '0;
        r.status = STAT_OK;
        found    = 1'b0;
        if (op == OP_PUSH) begin
            if (lvl < 1 || lvl > LEVELS) begin
                r.status = STAT_BAD_LEVEL;
            end
            else begin
                q    = lvl - 1;
                prod = int'(lvl) * int'(unit_now);
                r.slice = (sl_in == 0) ? prod[SLICE_W-1:0] : sl_in;
                r.level = lvl;
                if (ring_count[q] >= DEPTH) begin
                    r.status = STAT_FULL;
                end
                else begin
                    ring_id[q][ring_tail[q]]    = tid;
                    ring_slice[q][ring_tail[q]] = r.slice;
                    ring_tail[q]  = (ring_tail[q] + 1) % DEPTH;
                    ring_count[q] = ring_count[q] + 1;
                end
            end
        end
        else begin
            for (q = 0; q < LEVELS; q++) begin
                if (!found && ring_count[q] != 0) begin
                    r.task_id     = ring_id[q][ring_head[q]];
                    r.slice       = ring_slice[q][ring_head[q]];
                    r.level       = LVL_W'(q + 1);
                    ring_head[q]  = (ring_head[q] + 1) % DEPTH;
                    ring_count[q] = ring_count[q] - 1;
                    found         = 1'b1;
                end
            end
            if (!found)
                r.status = STAT_EMPTY;
        end
        held = 0;
        for (q = 0; q < LEVELS; q++)
            held += ring_count[q];
        r.occ = held[OCC_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        sched_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                ring_head[i]  = 0;
                ring_tail[i]  = 0;
                ring_count[i] = 0;
            end
            unit_now   = UNIT_RESET;
            fail_count = 0;
            sched_q.delete();
            awaiting <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                unit_now = cfg_data;
            if (m_axis_tvalid && m_axis_tready) begin
                if (sched_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, tdata %h tuser %0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end
                else begin
                    want = sched_q.pop_front();
                    check_field("status", want.status, m_axis_tuser);
                    check_field("task_out", want.task_id, m_axis_tdata[7:0]);
                    check_field("slice_out", want.slice, m_axis_tdata[18:8]);
                    check_field("level_out", want.level, m_axis_tdata[21:19]);
                    check_field("occupancy", want.occ, m_axis_tdata[28:22]);
                    check_field("tdata padding", 0, m_axis_tdata[31:29]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                sched_q.push_back(schedule_op(opcode_t'(s_axis_tuser), s_axis_tdata[7:0],
                                              s_axis_tdata[10:8], s_axis_tdata[21:11]));
            awaiting <= sched_q.size();
        end
    end

endmodule

@@ tb/multilevel_priority_task_queue_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multilevel_priority_task_queue_unit_tb
// Drives pushes and pops into the task queue: a directed opening for empty
// pops, bad levels, default slices and a full level, then random traffic in
// fill and drain bursts under several slice units and idling patterns.
// ----------------------------------------------------------------------------

module multilevel_priority_task_queue_unit_tb;

    import mptq_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int CHUNKS      = 9;
    localparam int CHUNK_ITEMS = 58;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [UNIT_W-1:0]     cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata: [7:0] task_id, [10:8] level, [21:11] slice_in, [23:22] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // tuser: [0] opcode
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: [7:0] task_out, [18:8] slice_out, [21:19] level_out,
    //        [28:22] occupancy, [31:29] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // tuser: [1:0] status
    logic [1:0]            m_axis_tuser;

    int fail_count;
    int awaiting;
    int tx_idle_pct;
    int rx_idle_pct;
    int stall_cycles;

    multilevel_priority_task_queue_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mptq_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .awaiting      (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    // End the run when no channel has moved a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Leave valid high across back-to-back transactions; lower it only for a gap.
    task automatic send_task_op(opcode_t op, logic [ID_W-1:0] tid, logic [LVL_W-1:0] lvl,
                                logic [SLICE_W-1:0] sl);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, sl, lvl, tid};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain_queue();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_slice_unit(logic [UNIT_W-1:0] value);
        drain_queue();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_op(int pop_pct);
        opcode_t          op;
        logic [LVL_W-1:0] lvl;
        logic [SLICE_W-1:0] sl;
        int               pick;
        op   = ($urandom_range(99) < pop_pct) ? OP_POP : OP_PUSH;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            pick = $urandom_range(3);
            lvl  = (pick == 0) ? 3'd0 : 3'(4 + pick);
        end
        else
            lvl = LVL_W'($urandom_range(LEVELS, 1));
        pick = $urandom_range(99);
        if (pick < 30)
            sl = '0;
        else if (pick < 40)
            sl = '1;
        else
            sl = SLICE_W'($urandom_range(2047));
        send_task_op(op, ID_W'($urandom_range(255)), lvl, sl);
    endtask

    initial
    begin
        int pop_pct;
        int phase;
        logic [UNIT_W-1:0] unit_val;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PUSH;
        tx_idle_pct   = 37;
        rx_idle_pct   = 51;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset slice unit.
        send_task_op(OP_POP, 8'd0, 3'd0, 11'd0);
        send_task_op(OP_PUSH, 8'd1, 3'd0, 11'd5);
        send_task_op(OP_PUSH, 8'd2, 3'd7, 11'd2047);
        send_task_op(OP_PUSH, 8'd255, 3'd1, 11'd2047);
        send_task_op(OP_PUSH, 8'd0, 3'd3, 11'd0);
        send_task_op(OP_PUSH, 8'd170, 3'd2, 11'd1);
        send_task_op(OP_POP, 8'd85, 3'd5, 11'd1024);
        send_task_op(OP_POP, 8'd0, 3'd0, 11'd0);
        send_task_op(OP_POP, 8'd0, 3'd0, 11'd0);
        send_task_op(OP_POP, 8'd0, 3'd0, 11'd0);
        // Fill the lowest level, then overflow it by one.
        for (int i = 0; i <= DEPTH; i++)
            send_task_op(OP_PUSH, 8'(i + 16), 3'(LEVELS), (i == DEPTH) ? 11'd9 : 11'd0);

        for (int c = 0; c < CHUNKS; c++)
        begin
            phase = c / 3;
            case (c)
                0:       unit_val = 8'd1;
                1:       unit_val = 8'd255;
                2:       unit_val = 8'd0;
                default: unit_val = UNIT_W'($urandom_range(255, 1));
            endcase
            write_slice_unit(unit_val);
            if (c % 3 == 0)
            begin
                tx_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 51 : 0;
                rx_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 37 : 0;
            end
            // Two fill bursts then a drain burst per phase; the middle phase mixes.
            if (c % 3 == 2)
                pop_pct = 85;
            else if (c % 3 == 1 && phase == 1)
                pop_pct = 45;
            else
                pop_pct = 10;
            for (int n = 0; n < CHUNK_ITEMS; n++)
                send_random_op(pop_pct);
        end

        drain_queue();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
